// ----- src/huffman_bit_serial_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Huffman bit serial decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_SERIAL_DECODER_MACROS_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define HBSD_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("hbsd assertion failed");
// antecedent at one edge implies consequent at the next edge
`define HBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hbsd assertion failed");
`else
`define HBSD_ASSERT(lbl, clk, rstn, expr)
`define HBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/hbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman bit serial decoder package
// Sizes, request codes, status codes and the structs passed along the cells.
// ----------------------------------------------------------------------------
package hbsd_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int ACT_W  = 2;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 8;
    localparam int STAT_W = 2;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int ALEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int LCMP_W = (LEN_W > ALEN_W) ? LEN_W : ALEN_W;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DECODE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // one table entry as loaded
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } entry_t;

    // lookup token walking the cell row
    typedef struct packed {
        logic [ACC_W-1:0]  bits;
        logic [ACC_W-1:0]  mask;
        logic [ALEN_W-1:0] len;
        logic              found;
        logic [SYM_W-1:0]  sym;
    } query_t;

endpackage

// ----- src/hbsd_cell.sv -----
// ----------------------------------------------------------------------------
// Huffman bit serial decoder table cell
// Holds one code table entry and compares the passing lookup token with it.
// ----------------------------------------------------------------------------
module hbsd_cell import hbsd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   tbl_clear,
    input  logic   wr_en,
    input  entry_t wr_entry,
    input  logic   q_in_valid,
    input  query_t q_in,
    output logic   q_out_valid,
    output query_t q_out
);

    entry_t entry_reg;
    logic   entry_valid_reg;
    logic   q_valid_reg;
    query_t q_reg;
    query_t q_next;
    logic   hit;

    // first hit along the row wins, later cells only pass the token on
    always_comb begin
        hit = entry_valid_reg && !q_in.found
            && (LCMP_W'(entry_reg.len) == LCMP_W'(q_in.len))
            && ((ACC_W'(entry_reg.code) & q_in.mask) == q_in.bits);
        q_next = q_in;
        if (hit) begin
            q_next.found = 1'b1;
            q_next.sym   = entry_reg.sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            q_valid_reg     <= 1'b0;
        end else begin
            if (tbl_clear) begin
                entry_valid_reg <= 1'b0;
            end else if (wr_en) begin
                entry_valid_reg <= 1'b1;
            end
            q_valid_reg <= q_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_entry;
        end
        q_reg <= q_next;
    end

    assign q_out_valid = q_valid_reg;
    assign q_out       = q_reg;

endmodule

// ----- src/huffman_bit_serial_decoder.sv -----
// ----------------------------------------------------------------------------
// Huffman bit serial decoder
// Decodes a Huffman bit stream one bit per request against a loaded table.
// ----------------------------------------------------------------------------
// Usage: requests enter on s_valid/s_ready with s_action selecting clear
// table, load entry or decode one bit. Results leave on m_valid/m_ready as
// m_symbol and m_status (0 decoded, 1 no match at maximum length, 2 table
// full). Clear and a successful load give no result; a decode gives one
// only when a code completes or the maximum length is reached.
// Table entries sit in a row of TABLE_DEPTH cells. A decode sends one
// lookup token down the row, one cell per cycle, each cell comparing it
// with its entry; the first hit in load order marks the token.
// Clear and load are registered directly on accept. A decode passes from
// accept through the injection register, the cell row, the pending result
// register and the output register to m_valid; one request is in flight at
// a time, so a new request is accepted only once the last one is through.
// Reset empties the table and the accumulator and drops any pending result.
// When the receiver stalls, the result holds in the output register and no
// new request is accepted until that slot frees up.
// ----------------------------------------------------------------------------
`include "huffman_bit_serial_decoder_macros.svh"

module huffman_bit_serial_decoder import hbsd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [CODE_W-1:0] s_entry_code,
    input  logic [LEN_W-1:0]  s_entry_length,
    input  logic [SYM_W-1:0]  s_entry_symbol,
    input  logic              s_stream_bit,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol,
    output logic [STAT_W-1:0] m_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ACC_W-1:0]    acc_bits_reg;
    logic [ALEN_W-1:0]   acc_len_reg;
    logic                inj_valid_reg;
    query_t              inj_reg;
    logic                res_pend_reg;
    logic [SYM_W-1:0]    res_sym_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic                m_valid_reg;
    logic [SYM_W-1:0]    m_symbol_reg;
    logic [STAT_W-1:0]   m_status_reg;

    logic                s_accept;
    logic                tbl_full;
    logic                tbl_clear;
    logic                load_go;
    logic                m_fill;
    logic [ALEN_W-1:0]   acc_len_next;
    logic [ACC_W-1:0]    acc_mask_next;
    logic [ACC_W-1:0]    acc_bits_next;
    entry_t              wr_entry;
    query_t              chain_q [TABLE_DEPTH+1];
    logic                chain_v [TABLE_DEPTH+1];
    query_t              tail_q;
    logic                tail_v;

    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept  = s_valid && s_ready;
    assign tbl_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign tbl_clear = s_accept && (s_action == ACT_CLEAR);
    assign load_go   = s_accept && (s_action == ACT_LOAD) && !tbl_full;

    // output register takes a new result this cycle
    assign m_fill = (s_accept && (s_action == ACT_LOAD) && tbl_full)
                 || ((state_reg == S_DONE) && res_pend_reg && (!m_valid_reg || m_ready));

    // shift the new bit in and keep only the accumulated length
    assign acc_len_next  = acc_len_reg + ALEN_W'(1);
    assign acc_mask_next = ~({ACC_W{1'b1}} << acc_len_next);
    assign acc_bits_next = {acc_bits_reg[ACC_W-2:0], s_stream_bit} & acc_mask_next;

    assign wr_entry.code = s_entry_code;
    assign wr_entry.len  = s_entry_length;
    assign wr_entry.sym  = s_entry_symbol;

    assign chain_q[0] = inj_reg;
    assign chain_v[0] = inj_valid_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        hbsd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tbl_clear   (tbl_clear),
            .wr_en       (load_go && (count_reg[IDX_W-1:0] == IDX_W'(i))),
            .wr_entry    (wr_entry),
            .q_in_valid  (chain_v[i]),
            .q_in        (chain_q[i]),
            .q_out_valid (chain_v[i+1]),
            .q_out       (chain_q[i+1])
        );
    end

    assign tail_q = chain_q[TABLE_DEPTH];
    assign tail_v = chain_v[TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            acc_bits_reg  <= '0;
            acc_len_reg   <= '0;
            inj_valid_reg <= 1'b0;
            res_pend_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !m_fill) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        case (s_action)
                            ACT_CLEAR: begin
                                count_reg    <= '0;
                                acc_bits_reg <= '0;
                                acc_len_reg  <= '0;
                            end
                            ACT_LOAD: begin
                                if (tbl_full) begin
                                    m_valid_reg  <= 1'b1;
                                    m_symbol_reg <= '0;
                                    m_status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            ACT_DECODE: begin
                                acc_bits_reg  <= acc_bits_next;
                                acc_len_reg   <= acc_len_next;
                                inj_valid_reg <= 1'b1;
                                inj_reg.bits  <= acc_bits_next;
                                inj_reg.mask  <= acc_mask_next;
                                inj_reg.len   <= acc_len_next;
                                inj_reg.found <= 1'b0;
                                inj_reg.sym   <= '0;
                                state_reg     <= S_WALK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    inj_valid_reg <= 1'b0;
                    if (tail_v) begin
                        // a hit beats the length limit
                        if (tail_q.found) begin
                            res_pend_reg   <= 1'b1;
                            res_sym_reg    <= tail_q.sym;
                            res_status_reg <= ST_OK;
                            acc_bits_reg   <= '0;
                            acc_len_reg    <= '0;
                        end else if (acc_len_reg == ALEN_W'(MAX_CODE_LEN)) begin
                            res_pend_reg   <= 1'b1;
                            res_sym_reg    <= '0;
                            res_status_reg <= ST_NOMATCH;
                            acc_bits_reg   <= '0;
                            acc_len_reg    <= '0;
                        end else begin
                            res_pend_reg <= 1'b0;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!res_pend_reg) begin
                        state_reg <= S_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_symbol_reg <= res_sym_reg;
                        m_status_reg <= res_status_reg;
                        res_pend_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_status = m_status_reg;

    `HBSD_ASSERT(a_tail_in_walk, aclk, aresetn, !tail_v || (state_reg == S_WALK))
    `HBSD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH))
    `HBSD_ASSERT(a_acc_below_max, aclk, aresetn, (state_reg != S_IDLE) || (acc_len_reg < ALEN_W'(MAX_CODE_LEN)))
    `HBSD_ASSERT_NEXT(a_decode_walks, aclk, aresetn, s_accept && (s_action == ACT_DECODE), inj_valid_reg && (state_reg == S_WALK))

endmodule
